FILE: hdl/bba_pkg.sv
package bba_pkg;

   // default sizing of the free map
   localparam int NUM_BLOCKS_DEF      = 8192;
   localparam int RESERVED_BLOCKS_DEF = 261;

   // map storage geometry
   localparam int WORD_BITS   = 64;
   localparam int BYTE_BITS   = 8;
   localparam int GROUP_BITS  = 8;
   localparam int WORD_BYTES  = WORD_BITS / BYTE_BITS;
   localparam int POS_W       = $clog2(WORD_BITS);
   localparam int BYTE_IDX_W  = $clog2(WORD_BYTES);
   localparam int BIT_IDX_W   = $clog2(BYTE_BITS);
   localparam int GRP_IDX_W   = $clog2(GROUP_BITS);

   // payload field widths
   localparam int BLOCK_W = 13;
   localparam int COUNT_W = 14;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_ALLOCATED = 2'd0,
      ST_NONE_FREE = 2'd1,
      ST_FREED     = 2'd2,
      ST_WAS_FREE  = 2'd3
   } status_type;

   typedef struct packed {
      action_type           action;
      logic [BLOCK_W-1:0]   target_block;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [BLOCK_W-1:0]   granted_block;
      logic [COUNT_W-1:0]   free_blocks;
   } rsp_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_ABYTE,
      S_ABIT,
      S_FCHK
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       init_wr;
      logic       load;
      logic       scan_next;
      logic       scan_rd;
      logic       free_rd;
      logic       byte_sel;
      logic       alloc_commit;
      logic       free_commit;
      logic       respond;
      status_type rsp_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic init_last;
      logic alloc_op;
      logic range_bad;
      logic group_hit;
      logic group_last;
      logic bit_set;
   } sts_type;

   // map word contents after reset: free for reserved <= block < num
   function automatic logic [WORD_BITS-1:0] reset_word(input int unsigned word_idx,
                                                       input int unsigned num,
                                                       input int unsigned res);
      logic [WORD_BITS-1:0] w;
      int unsigned          blk;
      w = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         blk = word_idx * WORD_BITS + j;
         w[j] = (blk >= res) && (blk < num);
      end
      return w;
   endfunction

endpackage

FILE: hdl/bba_ctrl.sv
module bba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  bba_pkg::sts_type   sts,
   output bba_pkg::cmd_type   cmd
);

   bba_pkg::state_type state_ff;
   bba_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rsp_status = bba_pkg::ST_ALLOCATED;
      busy           = 1'b1;
      case (state_ff)
         bba_pkg::S_INIT: begin
            cmd.init_wr = 1'b1;
            if (sts.init_last) begin
               state_in = bba_pkg::S_IDLE;
            end
         end
         bba_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = bba_pkg::S_DISPATCH;
            end
         end
         bba_pkg::S_DISPATCH: begin
            if (sts.alloc_op) begin
               state_in = bba_pkg::S_SCAN;
            end else if (sts.range_bad) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = bba_pkg::ST_WAS_FREE;
               state_in       = bba_pkg::S_IDLE;
            end else begin
               cmd.free_rd = 1'b1;
               state_in    = bba_pkg::S_FCHK;
            end
         end
         bba_pkg::S_SCAN: begin
            if (sts.group_hit) begin
               cmd.scan_rd = 1'b1;
               state_in    = bba_pkg::S_ABYTE;
            end else if (sts.group_last) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = bba_pkg::ST_NONE_FREE;
               state_in       = bba_pkg::S_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         bba_pkg::S_ABYTE: begin
            cmd.byte_sel = 1'b1;
            state_in     = bba_pkg::S_ABIT;
         end
         bba_pkg::S_ABIT: begin
            cmd.alloc_commit = 1'b1;
            cmd.respond      = 1'b1;
            cmd.rsp_status   = bba_pkg::ST_ALLOCATED;
            state_in         = bba_pkg::S_IDLE;
         end
         bba_pkg::S_FCHK: begin
            cmd.respond = 1'b1;
            if (sts.bit_set) begin
               cmd.rsp_status = bba_pkg::ST_WAS_FREE;
            end else begin
               cmd.free_commit = 1'b1;
               cmd.rsp_status  = bba_pkg::ST_FREED;
            end
            state_in = bba_pkg::S_IDLE;
         end
         default: begin
            state_in = bba_pkg::S_INIT;
         end
      endcase
   end

endmodule

FILE: hdl/bba_dpath.sv
module bba_dpath #(
   parameter int NUM_BLOCKS      = bba_pkg::NUM_BLOCKS_DEF,
   parameter int RESERVED_BLOCKS = bba_pkg::RESERVED_BLOCKS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  bba_pkg::req_type   req_payload,
   input  bba_pkg::cmd_type   cmd,
   output bba_pkg::sts_type   sts,
   output logic               rsp_strobe,
   output bba_pkg::rsp_type   rsp_payload
);

   localparam int WB      = bba_pkg::WORD_BITS;
   localparam int GB      = bba_pkg::GROUP_BITS;
   localparam int NW      = (NUM_BLOCKS + WB - 1) / WB;
   localparam int NG      = (NW + GB - 1) / GB;
   localparam int AW      = (NW > 1) ? $clog2(NW) : 1;
   localparam int GW      = (NG > 1) ? $clog2(NG) : 1;
   localparam int CW      = $clog2(NUM_BLOCKS + 1);
   localparam int RES_EFF = (RESERVED_BLOCKS > NUM_BLOCKS) ? NUM_BLOCKS : RESERVED_BLOCKS;

   bba_pkg::req_type                    req_ff;
   logic [WB-1:0]                       mem [NW];
   logic [WB-1:0]                       rd_data_ff;
   logic [AW-1:0]                       addr_ff;
   logic [AW-1:0]                       init_ff;
   logic [GW-1:0]                       grp_ff;
   logic [NW-1:0]                       sum_ff;
   logic [CW-1:0]                       count_ff;
   logic [CW-1:0]                       count_in;
   logic [bba_pkg::BYTE_IDX_W-1:0]      byte_ff;
   logic [bba_pkg::BYTE_IDX_W-1:0]      byte_in;
   logic                                strobe_ff;
   bba_pkg::rsp_type                    rsp_ff;

   logic [NG*GB-1:0]                    sum_pad;
   logic [GB-1:0]                       grp_bits;
   logic [bba_pkg::GRP_IDX_W-1:0]       grp_first;
   logic [AW-1:0]                       scan_addr;
   logic [31:0]                         blk32;
   logic [AW-1:0]                       free_addr;
   logic [bba_pkg::POS_W-1:0]           free_pos;
   logic [bba_pkg::BYTE_BITS-1:0]       byte_bits;
   logic [bba_pkg::BIT_IDX_W-1:0]       bit_first;
   logic [bba_pkg::POS_W-1:0]           alloc_pos;
   logic [WB-1:0]                       alloc_word;
   logic [WB-1:0]                       free_word;
   logic [WB-1:0]                       init_word;
   logic                                wr_en;
   logic [AW-1:0]                       wr_addr;
   logic [WB-1:0]                       wr_data;
   logic                                rd_en;
   logic [AW-1:0]                       rd_addr;
   logic [bba_pkg::BLOCK_W-1:0]         granted;

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
   end

   // summary scan: one group of eight map words per cycle
   always_comb begin
      sum_pad = '0;
      sum_pad[NW-1:0] = sum_ff;
   end

   assign grp_bits = sum_pad[32'(grp_ff) * GB +: GB];

   always_comb begin
      grp_first = '0;
      for (int i = GB - 1; i >= 0; i--) begin
         if (grp_bits[i]) begin
            grp_first = bba_pkg::GRP_IDX_W'(i);
         end
      end
   end

   assign scan_addr = AW'(32'(grp_ff) * GB + 32'(grp_first));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         grp_ff <= '0;
      end else if (cmd.scan_next) begin
         grp_ff <= grp_ff + 1'b1;
      end
   end

   // free request address split
   assign blk32     = 32'(req_ff.target_block);
   assign free_addr = AW'(blk32 / WB);
   assign free_pos  = bba_pkg::POS_W'(blk32 % WB);

   // lowest nonzero byte of the fetched word
   always_comb begin
      byte_in = '0;
      for (int i = bba_pkg::WORD_BYTES - 1; i >= 0; i--) begin
         if (|rd_data_ff[i*bba_pkg::BYTE_BITS +: bba_pkg::BYTE_BITS]) begin
            byte_in = bba_pkg::BYTE_IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.byte_sel) begin
         byte_ff <= byte_in;
      end
   end

   // lowest set bit within the chosen byte
   assign byte_bits = rd_data_ff[32'(byte_ff) * bba_pkg::BYTE_BITS +: bba_pkg::BYTE_BITS];

   always_comb begin
      bit_first = '0;
      for (int i = bba_pkg::BYTE_BITS - 1; i >= 0; i--) begin
         if (byte_bits[i]) begin
            bit_first = bba_pkg::BIT_IDX_W'(i);
         end
      end
   end

   assign alloc_pos  = {byte_ff, bit_first};
   assign alloc_word = rd_data_ff & ~(WB'(1) << alloc_pos);
   assign free_word  = rd_data_ff | (WB'(1) << free_pos);
   assign init_word  = bba_pkg::reset_word(32'(init_ff), NUM_BLOCKS, RESERVED_BLOCKS);
   assign granted    = bba_pkg::BLOCK_W'(32'(addr_ff) * WB + 32'(alloc_pos));

   // memory port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = alloc_word;
      if (cmd.init_wr) begin
         wr_en   = 1'b1;
         wr_addr = init_ff;
         wr_data = init_word;
      end else if (cmd.alloc_commit) begin
         wr_en   = 1'b1;
      end else if (cmd.free_commit) begin
         wr_en   = 1'b1;
         wr_data = free_word;
      end
   end

   assign rd_en   = cmd.scan_rd | cmd.free_rd;
   assign rd_addr = cmd.scan_rd ? scan_addr : free_addr;

   // free map words
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         addr_ff <= rd_addr;
      end
   end

   // init pointer, summary bits and free count
   always_comb begin
      count_in = count_ff;
      if (cmd.alloc_commit && (count_ff != '0)) begin
         count_in = count_ff - 1'b1;
      end else if (cmd.free_commit) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff  <= '0;
         sum_ff   <= '0;
         count_ff <= CW'(NUM_BLOCKS - RES_EFF);
      end else begin
         if (cmd.init_wr) begin
            init_ff <= init_ff + 1'b1;
         end
         if (wr_en) begin
            sum_ff[wr_addr] <= |wr_data;
         end
         count_ff <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff.status        <= cmd.rsp_status;
         rsp_ff.granted_block <= (cmd.rsp_status == bba_pkg::ST_ALLOCATED) ? granted : '0;
         rsp_ff.free_blocks   <= bba_pkg::COUNT_W'(32'(count_in));
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

   // status to controller
   assign sts.init_last  = (init_ff == AW'(NW - 1));
   assign sts.alloc_op   = (req_ff.action == bba_pkg::ACT_ALLOC);
   assign sts.range_bad  = (blk32 >= 32'(NUM_BLOCKS));
   assign sts.group_hit  = |grp_bits;
   assign sts.group_last = (grp_ff == GW'(NG - 1));
   assign sts.bit_set    = rd_data_ff[free_pos];

`ifndef SYNTHESIS
   // an allocation only lands in a word the summary marks as holding free blocks
   a_alloc_summary: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_commit |-> sum_ff[addr_ff])
      else $error("allocation from a word with no free block");

   // the fetched word for an allocation is never empty
   a_alloc_word: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_commit |-> (rd_data_ff != '0))
      else $error("allocation from an empty map word");

   // a free of a used block raises the count by one
   a_free_count: assert property (@(posedge clock) disable iff (reset)
      cmd.free_commit |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("free count not raised on free");

   // a granted block number only comes with an allocation
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && (rsp_ff.status != bba_pkg::ST_ALLOCATED)) |->
         (rsp_ff.granted_block == '0))
      else $error("nonzero block number without allocation");
`endif

endmodule

FILE: hdl/bitmap_block_allocator.sv
// first-fit block allocator over a 64-bit-word free map with a per-word summary
// free: the word is read from S_DISPATCH, its bit checked in S_FCHK, then the result register strobes;
//   a block beyond the map is answered from S_DISPATCH. allocate: the summary groups of 8 words
//   are scanned in order, S_ABYTE picks the byte and S_ABIT commits the bit; none free answers at the last group
// reset: busy while every map word is written
// results are never held off: the next start is taken in the strobe cycle
module bitmap_block_allocator #(
   parameter int NUM_BLOCKS      = bba_pkg::NUM_BLOCKS_DEF,
   parameter int RESERVED_BLOCKS = bba_pkg::RESERVED_BLOCKS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  bba_pkg::req_type   req_payload,
   output logic               rsp_strobe,
   output bba_pkg::rsp_type   rsp_payload
);

   bba_pkg::cmd_type cmd;
   bba_pkg::sts_type sts;

   // sequencer
   bba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // map storage, scan and count
   bba_dpath #(
      .NUM_BLOCKS      (NUM_BLOCKS),
      .RESERVED_BLOCKS (RESERVED_BLOCKS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule
